/* rtl/tpi_pkg.sv */
// shared types, constants and the channel expansion lookup for the icon decoder
package tpi_pkg;

   // register file geometry
   localparam int PAL_REGS       = 4;
   localparam int PAL_ENTRIES    = 16;
   localparam int ENTRIES_PER_REG = 4;
   localparam int COLOR_W        = 15;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = ENTRIES_PER_REG * COLOR_W;

   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [3:0] NIB_TRANSPARENT = 4'h0;

   // floor(c * 255 / 31) for every 5-bit channel value
   localparam logic [7:0] EXPAND5_LUT [32] = '{
      8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
      8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
      8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
      8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
   };

   typedef struct packed {
      logic [8:0] byte_index;
      logic [7:0] pixel_byte;
   } req_type;

   typedef struct packed {
      logic [4:0] pixel_x;
      logic [4:0] pixel_y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last_of_pair;
   } rsp_type;

   // byte after position decode, as it sits in the queue
   typedef struct packed {
      logic [4:0] x_base;
      logic [4:0] y;
      logic [3:0] nib_lo;
      logic [3:0] nib_hi;
   } item_type;

   function automatic logic [7:0] expand5(input logic [4:0] c);
      return EXPAND5_LUT[c];
   endfunction

endpackage

/* rtl/tpi_front.sv */
// front end: takes bitmap bytes and decodes tile layout into pixel position
module tpi_front import tpi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_payload,
   output logic     push_valid,
   input  logic     push_ready,
   output item_type push_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   // stage is free when empty or when it drains this cycle
   assign req_ready  = !valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   // tile layout: index = (ty*4 + tx)*32 + row*4 + pair
   always_comb begin
      item_in.x_base = {req_payload.byte_index[6:5], req_payload.byte_index[1:0], 1'b0};
      item_in.y      = {req_payload.byte_index[8:7], req_payload.byte_index[4:2]};
      item_in.nib_lo = req_payload.pixel_byte[3:0];
      item_in.nib_hi = req_payload.pixel_byte[7:4];
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

/* rtl/tpi_queue.sv */
// short fifo of decoded bytes between front and back end
module tpi_queue import tpi_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   item_type           slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != COUNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/tpi_back.sv */
// back end: palette registers, color lookup and two pixel transfers per byte
module tpi_back import tpi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  item_type               pop_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload
);

   logic [PAL_ENTRIES-1:0][COLOR_W-1:0] pal_ff;
   logic                                 phase_ff, phase_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   rsp_type                              rsp_ff, rsp_in;
   logic                                 out_free, load;
   logic [3:0]                           nib;
   logic [COLOR_W-1:0]                   color;

   assign csr_ready = 1'b1;

   // palette writes, indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         pal_ff <= '0;
      end else if (csr_valid && (csr_index < CSR_INDEX_W'(PAL_REGS))) begin
         pal_ff[{csr_index[1:0], 2'b00} +: ENTRIES_PER_REG] <= csr_data;
      end
   end

   // output register takes a pixel when empty or being drained
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load      = out_free && pop_valid;
   assign pop_ready = out_free && phase_ff;

   // pixel build: low nibble on phase 0, high nibble on phase 1
   always_comb begin
      nib   = phase_ff ? pop_item.nib_hi : pop_item.nib_lo;
      color = pal_ff[nib];
      rsp_in.pixel_x      = {pop_item.x_base[4:1], phase_ff};
      rsp_in.pixel_y      = pop_item.y;
      rsp_in.red          = expand5(color[4:0]);
      rsp_in.green        = expand5(color[9:5]);
      rsp_in.blue         = expand5(color[14:10]);
      rsp_in.alpha        = (nib == NIB_TRANSPARENT) ? ALPHA_CLEAR : ALPHA_OPAQUE;
      rsp_in.last_of_pair = phase_ff;
   end

   always_comb begin
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         phase_in     = !phase_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // first pixel of a byte is always followed by the second one
   a_first_then_second: assert property (@(posedge clock) disable iff (reset)
      (load && !phase_ff) |=> phase_ff)
      else $error("phase did not advance after first pixel");

   // a second-pixel load shows up flagged as last of pair
   a_second_flagged: assert property (@(posedge clock) disable iff (reset)
      (load && phase_ff) |=> (rsp_valid_ff && rsp_ff.last_of_pair))
      else $error("second pixel not flagged");

   // left pixel sits on an even column, right pixel on odd
   a_column_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.pixel_x[0] == rsp_ff.last_of_pair))
      else $error("pixel column parity mismatch");

   // alpha is either fully clear or fully opaque
   a_alpha_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.alpha == ALPHA_CLEAR || rsp_ff.alpha == ALPHA_OPAQUE))
      else $error("alpha out of range");

endmodule

/* rtl/tiled_palette_icon_to_rgba.sv */
// top level of the tiled 4bpp palette icon to rgba decoder
// Each req transfer carries one bitmap byte of a 32x32 icon stored as 4x4 tiles of
// 8x8 pixels, and yields two rsp transfers: the low-nibble (left) pixel, then the
// high-nibble pixel with last_of_pair set. Each byte thus needs two transfers on the
// single result channel, which moves one pixel per cycle unless rsp_ready stalls it;
// a req passes the front register, the queue and the output register. The front end
// decodes position and the back end looks up the 16-entry BGR555 palette and expands
// each channel to 8 bits; a small queue between them absorbs short bursts. The
// palette is written through the csr port (index 0..3, four colors per write,
// higher indexes ignored) and should only change while no pixels are in flight.
module tiled_palette_icon_to_rgba import tpi_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;

   tpi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   tpi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   tpi_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_item    (pop_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* verif/tb_tiled_palette_icon_to_rgba.sv */
// self-checking testbench for the tiled 4bpp palette icon to rgba decoder
module tb_tiled_palette_icon_to_rgba;
   import tpi_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam int PHASES         = 8;
   localparam int PHASE_BYTES    = 235;
   localparam int DRAIN_CYCLES   = 12;
   localparam int MAX_WAIT       = 19;

   // palette register indexes, plus the unused range above them
   localparam logic [CSR_INDEX_W-1:0] REG_PAL_0_3      = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_PAL_4_7      = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_PAL_8_11     = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_PAL_12_15    = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_FIRST = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_LAST  = CSR_INDEX_W'(7);

   // kinds of palette programming
   localparam int PAL_CLEAR  = 0;
   localparam int PAL_FULL   = 1;
   localparam int PAL_RANDOM = 2;
   localparam int PAL_MIXED  = 3;

   // directed bytes: corner tiles, tile edges, nibble extremes
   localparam logic [8:0] DIRECTED_INDEX [12] = '{
      9'd0, 9'd511, 9'd31, 9'd480, 9'd3, 9'd28, 9'd37, 9'd255, 9'd256, 9'd100, 9'd447, 9'd64
   };
   localparam logic [7:0] DIRECTED_BYTE [12] = '{
      8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h01, 8'h10, 8'hA5, 8'h5A, 8'hE1, 8'h1E, 8'h77, 8'h88
   };

   // expected pixel stream and the palette it is decoded against
   class icon_scoreboard;
      logic [CSR_DATA_W-1:0] palette [PAL_REGS];
      rsp_type pending_pixels [$];
      int mismatches;

      function new();
         foreach (palette[i]) palette[i] = '0;
         mismatches = 0;
      endfunction

      function void write_palette(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx < PAL_REGS) palette[idx] = data;
      endfunction

      // 5-bit channel to 8 bits, rounding down
      function logic [7:0] widen(logic [4:0] c);
         int v;
         v = int'(c) * 255 / 31;
         return v[7:0];
      endfunction

      function rsp_type decode_nibble(logic [3:0] nib, logic [4:0] x, logic [4:0] y,
                                      logic second);
         rsp_type p;
         logic [COLOR_W-1:0] color;
         color = palette[nib[3:2]][nib[1:0]*COLOR_W +: COLOR_W];
         p.pixel_x      = x;
         p.pixel_y      = y;
         p.red          = widen(color[4:0]);
         p.green        = widen(color[9:5]);
         p.blue         = widen(color[14:10]);
         p.alpha        = (nib == NIB_TRANSPARENT) ? ALPHA_CLEAR : ALPHA_OPAQUE;
         p.last_of_pair = second;
         return p;
      endfunction

      // byte index is {tile_y, tile_x, row, pair}
      function void note_byte(req_type b);
         logic [4:0] x;
         logic [4:0] y;
         x = {b.byte_index[6:5], b.byte_index[1:0], 1'b0};
         y = {b.byte_index[8:7], b.byte_index[4:2]};
         pending_pixels.push_back(decode_nibble(b.pixel_byte[3:0], x, y, 1'b0));
         pending_pixels.push_back(decode_nibble(b.pixel_byte[7:4], x | 5'd1, y, 1'b1));
      endfunction

      function void check_pixel(rsp_type got);
         rsp_type want;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected pixel: x=%0d y=%0d rgba=%0d,%0d,%0d,%0d last=%0d",
                        got.pixel_x, got.pixel_y, got.red, got.green, got.blue,
                        got.alpha, got.last_of_pair);
            return;
         end
         want = pending_pixels.pop_front();
         if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
             got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
             got.alpha !== want.alpha || got.last_of_pair !== want.last_of_pair) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("pixel mismatch: want x=%0d y=%0d rgba=%0d,%0d,%0d,%0d last=%0d",
                        want.pixel_x, want.pixel_y, want.red, want.green, want.blue,
                        want.alpha, want.last_of_pair);
               $display("                got  x=%0d y=%0d rgba=%0d,%0d,%0d,%0d last=%0d",
                        got.pixel_x, got.pixel_y, got.red, got.green, got.blue,
                        got.alpha, got.last_of_pair);
            end
         end
      endfunction

      function int outstanding();
         return pending_pixels.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   icon_scoreboard pixels_sb;
   bit             steady_req;
   bit             steady_rsp;
   int             quiet_cycles = 0;

   tiled_palette_icon_to_rgba dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // transfer monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) pixels_sb.write_palette(csr_index, csr_data);
         if (req_valid && req_ready) pixels_sb.note_byte(req_payload);
         if (rsp_valid && rsp_ready) pixels_sb.check_pixel(rsp_payload);
      end
      if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
   end

   // pixel sink with random back pressure
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         stall = steady_rsp ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   function automatic req_type make_req(logic [8:0] idx, logic [7:0] b);
      req_type r;
      r.byte_index = idx;
      r.pixel_byte = b;
      return r;
   endfunction

   // valid stays high into the next byte when no gap is drawn
   task automatic send_byte(input req_type item);
      int gap;
      gap = steady_req ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] palette_value(int style);
      case (style)
         PAL_CLEAR: begin
            return '0;
         end
         PAL_FULL: begin
            return '1;
         end
         default: begin
            return CSR_DATA_W'({$urandom, $urandom});
         end
      endcase
   endfunction

   // all four palette registers, sometimes followed by a write to an unused index
   task automatic program_palette(input int style);
      logic [CSR_INDEX_W-1:0] regs [PAL_REGS];
      int pick;
      regs = '{REG_PAL_0_3, REG_PAL_4_7, REG_PAL_8_11, REG_PAL_12_15};
      foreach (regs[i]) begin
         pick = (style == PAL_MIXED) ? $urandom_range(PAL_CLEAR, PAL_RANDOM) : style;
         write_reg(regs[i], palette_value(pick));
      end
      if ($urandom_range(0, 1))
         write_reg(CSR_INDEX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                   palette_value(PAL_RANDOM));
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pixels_sb.outstanding() != 0);
   endtask

   // stimulus
   initial begin
      logic [8:0] sweep;
      logic [8:0] idx;
      pixels_sb    = new();
      steady_req   = 1'b0;
      steady_rsp   = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // palette still at its reset value
      send_byte(make_req(9'd0, 8'hFF));
      send_byte(make_req(9'd511, 8'h00));
      req_valid <= 1'b0;
      wait_drained();

      // directed bytes, then every nibble value once: even values low, odd values high
      program_palette(PAL_RANDOM);
      for (int i = 0; i < 12; i++) send_byte(make_req(DIRECTED_INDEX[i], DIRECTED_BYTE[i]));
      for (int n = 0; n < 8; n++)
         send_byte(make_req(9'($urandom), {4'(2*n+1), 4'(2*n)}));
      req_valid <= 1'b0;
      wait_drained();

      // random phases: in-order icon scans mixed with scattered bytes
      for (int phase = 0; phase < PHASES; phase++) begin
         steady_req = 1'b0;
         steady_rsp = 1'b0;
         if (phase == 0) program_palette(PAL_CLEAR);
         else if (phase == 1) program_palette(PAL_FULL);
         else if (phase % 2 == 1) program_palette(PAL_MIXED);
         else program_palette(PAL_RANDOM);
         steady_req = (phase % 3 == 2);
         steady_rsp = (phase % 4 == 3);
         sweep = 9'($urandom);
         for (int n = 0; n < PHASE_BYTES; n++) begin
            if ($urandom_range(0, 1)) begin
               idx   = sweep;
               sweep = sweep + 9'd1;
            end else begin
               idx = 9'($urandom);
            end
            send_byte(make_req(idx, 8'($urandom)));
         end
         req_valid <= 1'b0;
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pixels_sb.mismatches == 0 && pixels_sb.outstanding() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
